### sv/jdcal_pkg.sv
// Shared constants and stage payload types for the Julian day to calendar date converter.
// No dependencies; used by julian_day_to_calendar_date.
package jdcal_pkg;

   // Supported span: 1 January of year 1 through 31 December of year 9999
   localparam logic [22:0] JD_FIRST = 23'd1721426;
   localparam logic [22:0] JD_LAST  = 23'd5373484;

   // Conversion constants
   localparam logic [15:0] JD_OFFSET  = 16'd32044;
   localparam logic [17:0] DAYS_400Y  = 18'd146097;
   localparam logic [10:0] DAYS_4Y    = 11'd1461;
   localparam logic [7:0]  DAYS_5MON  = 8'd153;
   localparam logic [12:0] YEAR_BASE  = 13'd4800;
   localparam logic [6:0]  YEAR_SCALE = 7'd100;

   // Reciprocal multipliers: floor(2^shift / divisor), but RCP_FIVE is rounded up; the
   // floored quotient estimates are low by at most one and are fixed by a remainder compare
   localparam logic [7:0]  RCP_400Y = 8'd229;        // shift 25
   localparam logic [7:0]  RCP_4Y   = 8'd179;        // shift 18
   localparam logic [3:0]  RCP_5MON = 4'd13;         // shift 11
   localparam logic [20:0] RCP_WEEK = 21'd1198372;   // shift 23
   localparam logic [7:0]  RCP_FIVE = 8'd205;        // shift 10, exact below 153

   localparam logic [2:0]  DAYS_WEEK = 3'd7;

   localparam int unsigned NUM_STAGES = 11;

   typedef struct packed {
      logic        err;
      logic [22:0] a;
      logic [22:0] w;
   } s1_type;

   typedef struct packed {
      logic        err;
      logic [24:0] x1;
      logic [7:0]  bq;
      logic [22:0] w;
      logic [19:0] wq;
   } s2_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  bq;
      logic [18:0] r1;
      logic [3:0]  wr;
   } s3_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  b;
      logic [15:0] c;
      logic [2:0]  wd;
   } s4_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  b;
      logic [17:0] x2;
      logic [6:0]  dq;
      logic [2:0]  wd;
   } s5_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  b;
      logic [6:0]  dq;
      logic [11:0] r2;
      logic [2:0]  wd;
   } s6_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  b;
      logic [6:0]  d;
      logic [8:0]  e;
      logic [2:0]  wd;
   } s7_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  b;
      logic [6:0]  d;
      logic [11:0] x3;
      logic [3:0]  mq;
      logic [2:0]  wd;
   } s8_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  b;
      logic [6:0]  d;
      logic [3:0]  mq;
      logic [8:0]  r3;
      logic [2:0]  wd;
   } s9_type;

   typedef struct packed {
      logic        err;
      logic [7:0]  b;
      logic [6:0]  d;
      logic [3:0]  m;
      logic [7:0]  rr3;
      logic [2:0]  wd;
   } s10_type;

   typedef struct packed {
      logic        err;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  weekday;
   } out_type;

endpackage

### sv/julian_day_to_calendar_date.sv
// Julian day number to Gregorian date and weekday, eleven-stage pipeline.
// A transaction accepted at a clock edge passes through s1_ff to s10_ff and out_ff before rsp_strobe.
// Throughput: one transaction per clock; busy is never raised, no back-pressure.
// Most stages hold multiplies by constants or remainder compares and subtracts.
// Reset (synchronous, active high) clears the stage valid bits; payload is not reset.
// Depends on jdcal_pkg.
module julian_day_to_calendar_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [22:0] req_julian_day,
   output logic        rsp_strobe,
   output logic [13:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [2:0]  rsp_weekday,
   output logic        rsp_range_error
);

   logic [jdcal_pkg::NUM_STAGES-1:0] vld_ff, vld_in;

   jdcal_pkg::s1_type  s1_ff,  s1_in;
   jdcal_pkg::s2_type  s2_ff,  s2_in;
   jdcal_pkg::s3_type  s3_ff,  s3_in;
   jdcal_pkg::s4_type  s4_ff,  s4_in;
   jdcal_pkg::s5_type  s5_ff,  s5_in;
   jdcal_pkg::s6_type  s6_ff,  s6_in;
   jdcal_pkg::s7_type  s7_ff,  s7_in;
   jdcal_pkg::s8_type  s8_ff,  s8_in;
   jdcal_pkg::s9_type  s9_ff,  s9_in;
   jdcal_pkg::s10_type s10_ff, s10_in;
   jdcal_pkg::out_type out_ff, out_in;

   // Intermediate products
   logic [24:0] x1_w;
   logic [32:0] prod_b;
   logic [43:0] prod_w;
   logic [24:0] r1_full;
   logic [22:0] wr_full;
   logic        b_corr;
   logic [18:0] r1_fix;
   logic [17:0] x2_w;
   logic [25:0] prod_d;
   logic [17:0] r2_full;
   logic        d_corr;
   logic [11:0] r2_fix;
   logic [11:0] x3_w;
   logic [15:0] prod_m;
   logic [11:0] r3_full;
   logic        m_corr;
   logic [15:0] prod_dy;
   logic        m_hi;
   logic [14:0] year_full;

   // Pipeline never stalls
   assign busy = 1'b0;

   // Advance valid bits
   assign vld_in = {vld_ff[jdcal_pkg::NUM_STAGES-2:0], start & ~busy};

   // Stage 1: offset and range check
   always_comb begin
      s1_in.err = (req_julian_day < jdcal_pkg::JD_FIRST) ||
                  (req_julian_day > jdcal_pkg::JD_LAST);
      s1_in.a   = req_julian_day + 23'(jdcal_pkg::JD_OFFSET);
      s1_in.w   = req_julian_day + 23'd1;
   end

   // Stage 2: estimate 400-year cycle and week quotients
   always_comb begin
      x1_w        = {s1_ff.a, 2'b00} + 25'd3;
      prod_b      = 33'(x1_w) * 33'(jdcal_pkg::RCP_400Y);
      prod_w      = 44'(s1_ff.w) * 44'(jdcal_pkg::RCP_WEEK);
      s2_in.err   = s1_ff.err;
      s2_in.x1    = x1_w;
      s2_in.bq    = prod_b[32:25];
      s2_in.w     = s1_ff.w;
      s2_in.wq    = prod_w[42:23];
   end

   // Stage 3: remainders of the estimates
   always_comb begin
      r1_full   = s2_ff.x1 - 25'(26'(s2_ff.bq) * 26'(jdcal_pkg::DAYS_400Y));
      wr_full   = s2_ff.w - 23'(23'(s2_ff.wq) * 23'(jdcal_pkg::DAYS_WEEK));
      s3_in.err = s2_ff.err;
      s3_in.bq  = s2_ff.bq;
      s3_in.r1  = r1_full[18:0];
      s3_in.wr  = wr_full[3:0];
   end

   // Stage 4: fix quotients; day within the 400-year cycle
   always_comb begin
      b_corr    = s3_ff.r1 >= 19'(jdcal_pkg::DAYS_400Y);
      r1_fix    = b_corr ? s3_ff.r1 - 19'(jdcal_pkg::DAYS_400Y) : s3_ff.r1;
      s4_in.err = s3_ff.err;
      s4_in.b   = s3_ff.bq + 8'(b_corr);
      s4_in.c   = r1_fix[17:2];
      s4_in.wd  = (s3_ff.wr >= 4'(jdcal_pkg::DAYS_WEEK)) ?
                  3'(s3_ff.wr - 4'(jdcal_pkg::DAYS_WEEK)) : s3_ff.wr[2:0];
   end

   // Stage 5: estimate 4-year cycle quotient
   always_comb begin
      x2_w      = {s4_ff.c, 2'b00} + 18'd3;
      prod_d    = 26'(x2_w) * 26'(jdcal_pkg::RCP_4Y);
      s5_in.err = s4_ff.err;
      s5_in.b   = s4_ff.b;
      s5_in.x2  = x2_w;
      s5_in.dq  = prod_d[24:18];
      s5_in.wd  = s4_ff.wd;
   end

   // Stage 6: remainder of the 4-year estimate
   always_comb begin
      r2_full   = s5_ff.x2 - 18'(18'(s5_ff.dq) * 18'(jdcal_pkg::DAYS_4Y));
      s6_in.err = s5_ff.err;
      s6_in.b   = s5_ff.b;
      s6_in.dq  = s5_ff.dq;
      s6_in.r2  = r2_full[11:0];
      s6_in.wd  = s5_ff.wd;
   end

   // Stage 7: fix quotient; day within the March-based year
   always_comb begin
      d_corr    = s6_ff.r2 >= 12'(jdcal_pkg::DAYS_4Y);
      r2_fix    = d_corr ? s6_ff.r2 - 12'(jdcal_pkg::DAYS_4Y) : s6_ff.r2;
      s7_in.err = s6_ff.err;
      s7_in.b   = s6_ff.b;
      s7_in.d   = s6_ff.dq + 7'(d_corr);
      s7_in.e   = r2_fix[10:2];
      s7_in.wd  = s6_ff.wd;
   end

   // Stage 8: estimate month index
   always_comb begin
      x3_w      = 12'({s7_ff.e, 2'b00}) + 12'(s7_ff.e) + 12'd2;
      prod_m    = 16'(x3_w) * 16'(jdcal_pkg::RCP_5MON);
      s8_in.err = s7_ff.err;
      s8_in.b   = s7_ff.b;
      s8_in.d   = s7_ff.d;
      s8_in.x3  = x3_w;
      s8_in.mq  = prod_m[14:11];
      s8_in.wd  = s7_ff.wd;
   end

   // Stage 9: remainder of the month estimate
   always_comb begin
      r3_full   = s8_ff.x3 - 12'(12'(s8_ff.mq) * 12'(jdcal_pkg::DAYS_5MON));
      s9_in.err = s8_ff.err;
      s9_in.b   = s8_ff.b;
      s9_in.d   = s8_ff.d;
      s9_in.mq  = s8_ff.mq;
      s9_in.r3  = r3_full[8:0];
      s9_in.wd  = s8_ff.wd;
   end

   // Stage 10: fix month index
   always_comb begin
      m_corr     = s9_ff.r3 >= 9'(jdcal_pkg::DAYS_5MON);
      s10_in.err = s9_ff.err;
      s10_in.b   = s9_ff.b;
      s10_in.d   = s9_ff.d;
      s10_in.m   = s9_ff.mq + 4'(m_corr);
      s10_in.rr3 = m_corr ? 8'(s9_ff.r3 - 9'(jdcal_pkg::DAYS_5MON)) : s9_ff.r3[7:0];
      s10_in.wd  = s9_ff.wd;
   end

   // Stage 11: assemble the date; zero the fields when out of range
   always_comb begin
      prod_dy   = 16'(s10_ff.rr3) * 16'(jdcal_pkg::RCP_FIVE);
      m_hi      = s10_ff.m >= 4'd10;
      year_full = 15'(15'(s10_ff.b) * 15'(jdcal_pkg::YEAR_SCALE)) + 15'(s10_ff.d)
                  + 15'(m_hi) - 15'(jdcal_pkg::YEAR_BASE);
      out_in.err = s10_ff.err;
      if (s10_ff.err) begin
         out_in.year    = '0;
         out_in.month   = '0;
         out_in.day     = '0;
         out_in.weekday = '0;
      end else begin
         out_in.year    = year_full[13:0];
         out_in.month   = m_hi ? s10_ff.m - 4'd9 : s10_ff.m + 4'd3;
         out_in.day     = prod_dy[14:10] + 5'd1;
         out_in.weekday = s10_ff.wd;
      end
   end

   // Clear valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Move payload every cycle
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s4_ff  <= s4_in;
      s5_ff  <= s5_in;
      s6_ff  <= s6_in;
      s7_ff  <= s7_in;
      s8_ff  <= s8_in;
      s9_ff  <= s9_in;
      s10_ff <= s10_in;
      out_ff <= out_in;
   end

   // Drive result ports
   assign rsp_strobe      = vld_ff[jdcal_pkg::NUM_STAGES-1];
   assign rsp_year        = out_ff.year;
   assign rsp_month       = out_ff.month;
   assign rsp_day         = out_ff.day;
   assign rsp_weekday     = out_ff.weekday;
   assign rsp_range_error = out_ff.err;

`ifndef SYNTH
   // Each accepted transaction gives a result on rsp_strobe
   a_latency_hit: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##11 rsp_strobe)
      else $error("missing result after accepted transaction");

   // No result appears without a transaction behind it
   a_latency_idle: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##11 !rsp_strobe)
      else $error("result without a transaction");

   // An in-range result carries a legal date and weekday
   a_date_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_range_error) |->
         (rsp_year >= 14'd1 && rsp_year <= 14'd9999 && rsp_month >= 4'd1 &&
          rsp_month <= 4'd12 && rsp_day >= 5'd1 && rsp_weekday <= 3'd6))
      else $error("illegal date in result");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for julian_day_to_calendar_date: random and corner day numbers.
// Depends on jdcal_pkg and julian_day_to_calendar_date; holds the date scoreboard class and tb_top.

class calendar_scoreboard;
   jdcal_pkg::out_type pending_dates[$];
   int unsigned error_count   = 0;
   int unsigned checked_count = 0;
   int unsigned in_span_count = 0;
   int unsigned off_span_count = 0;

   // Convert one day number to year, month, day and weekday
   function jdcal_pkg::out_type convert_day(logic [22:0] jd);
      jdcal_pkg::out_type date;
      int unsigned a, b, c, d, e, m, n;
      n = jd;
      date = '0;
      if (jd < jdcal_pkg::JD_FIRST || jd > jdcal_pkg::JD_LAST) begin
         date.err = 1'b1;
         return date;
      end
      a = n + jdcal_pkg::JD_OFFSET;
      b = (4 * a + 3) / jdcal_pkg::DAYS_400Y;
      c = a - (jdcal_pkg::DAYS_400Y * b) / 4;
      d = (4 * c + 3) / jdcal_pkg::DAYS_4Y;
      e = c - (jdcal_pkg::DAYS_4Y * d) / 4;
      m = (5 * e + 2) / jdcal_pkg::DAYS_5MON;
      date.day     = 5'(e - (jdcal_pkg::DAYS_5MON * m + 2) / 5 + 1);
      date.month   = 4'(m + 3 - 12 * (m / 10));
      date.year    = 14'(jdcal_pkg::YEAR_SCALE * b + d + (m / 10) - jdcal_pkg::YEAR_BASE);
      date.weekday = 3'((n + 1) % jdcal_pkg::DAYS_WEEK);
      return date;
   endfunction

   // Queue the date that an accepted transaction must produce
   function void note_day(logic [22:0] jd);
      jdcal_pkg::out_type date;
      date = convert_day(jd);
      if (date.err) off_span_count++;
      else in_span_count++;
      pending_dates.push_back(date);
   endfunction

   function void compare_field(string name, logic [22:0] jd, int unsigned want,
                               int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch for day %0d: expected %0d, actual %0d",
                  $time, name, jd, want, got);
      end
   endfunction

   // Match one result transaction against the oldest pending date
   function void check_date(jdcal_pkg::out_type got, logic [22:0] jd);
      jdcal_pkg::out_type want;
      if (pending_dates.size() == 0) begin
         error_count++;
         $display("%0t: unexpected result: expected none, actual %0d-%0d-%0d wd %0d err %0b",
                  $time, got.year, got.month, got.day, got.weekday, got.err);
         return;
      end
      want = pending_dates.pop_front();
      checked_count++;
      compare_field("year", jd, want.year, got.year);
      compare_field("month", jd, want.month, got.month);
      compare_field("day", jd, want.day, got.day);
      compare_field("weekday", jd, want.weekday, got.weekday);
      compare_field("range_error", jd, want.err, got.err);
   endfunction

   function int unsigned outstanding();
      return pending_dates.size();
   endfunction
endclass

module tb_top;
   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [22:0] req_julian_day;
   logic        rsp_strobe;
   logic [13:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [2:0]  rsp_weekday;
   logic        rsp_range_error;

   calendar_scoreboard date_book = new();
   logic [22:0]        day_trail[$];
   logic [22:0]        corner_days[$];

   julian_day_to_calendar_date u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_julian_day  (req_julian_day),
      .rsp_strobe      (rsp_strobe),
      .rsp_year        (rsp_year),
      .rsp_month       (rsp_month),
      .rsp_day         (rsp_day),
      .rsp_weekday     (rsp_weekday),
      .rsp_range_error (rsp_range_error)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Record every accepted request transaction
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         date_book.note_day(req_julian_day);
         day_trail.push_back(req_julian_day);
      end
   end

   // Check every result transaction on its strobe
   always @(posedge clock) begin
      jdcal_pkg::out_type got;
      logic [22:0]        jd;
      if (!reset && rsp_strobe) begin
         got.err     = rsp_range_error;
         got.year    = rsp_year;
         got.month   = rsp_month;
         got.day     = rsp_day;
         got.weekday = rsp_weekday;
         jd = (day_trail.size() != 0) ? day_trail.pop_front() : '0;
         date_book.check_date(got, jd);
      end
   end

   // Present one day number and hold it until the block takes it
   task automatic send_day(input logic [22:0] jd);
      start          <= 1'b1;
      req_julian_day <= jd;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start for a random gap, mostly short, now and then long
   task automatic idle_gap();
      int unsigned pick;
      int unsigned gap;
      pick = $urandom_range(99);
      if (pick < 65) gap = 0;
      else if (pick < 93) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 8);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Hold off the sender until every pending date has come back
   task automatic drain_dates();
      start <= 1'b0;
      do @(negedge clock); while (date_book.outstanding() != 0);
   endtask

   function automatic logic [22:0] pick_day();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 72) return 23'($urandom_range(jdcal_pkg::JD_LAST, jdcal_pkg::JD_FIRST));
      if (pick < 78) return 23'(jdcal_pkg::JD_FIRST - 6 + $urandom_range(11));
      if (pick < 84) return 23'(jdcal_pkg::JD_LAST - 5 + $urandom_range(11));
      return 23'($urandom);
   endfunction

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      start          = 1'b0;
      req_julian_day = '0;
      reset          = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Span edges, field extremes, leap and century days, a full week
      corner_days = '{jdcal_pkg::JD_FIRST, jdcal_pkg::JD_LAST,
                      jdcal_pkg::JD_FIRST - 23'd1, jdcal_pkg::JD_LAST + 23'd1,
                      23'd0, 23'h7FFFFF,
                      23'd2299160, 23'd2299161, 23'd2305507, 23'd2415079, 23'd2415080,
                      23'd2451544, 23'd2451603, 23'd2451604, 23'd2451605,
                      23'd2451545, 23'd2451546, 23'd2451547, 23'd2451548, 23'd2451549,
                      23'd2451550, 23'd2451551, 23'd1722886, 23'd5373119, 23'h555555};
      foreach (corner_days[i]) send_day(corner_days[i]);

      // Random days; keep one stretch back to back and drain twice on the way
      for (int i = 0; i < 750; i++) begin
         if (i == 250 || i == 500) drain_dates();
         else if (i < 100 || i >= 170) idle_gap();
         send_day(pick_day());
      end

      start <= 1'b0;
      do @(negedge clock); while (date_book.outstanding() != 0);
      repeat (jdcal_pkg::NUM_STAGES + 4) @(negedge clock);

      $display("Converted %0d day numbers: %0d inside the year 1..9999 span, %0d outside.",
               date_book.checked_count, date_book.in_span_count, date_book.off_span_count);
      $display("Left unanswered: %0d; mismatches: %0d.",
               date_book.outstanding(), date_book.error_count);
      if (date_book.error_count == 0 && date_book.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

### julian_day_to_calendar_date.f
sv/jdcal_pkg.sv
sv/julian_day_to_calendar_date.sv
tb/sv/tb_top.sv
